### hdl/iafp_pkg.sv
// Package for the IMU angle frame parser: frame constants, control struct
// and the raw-to-angle conversion. No dependencies.
package iafp_pkg;

    localparam logic [7:0]  HDR_FIRST   = 8'h55;
    localparam logic [7:0]  HDR_SECOND  = 8'h53;
    localparam logic [7:0]  SUM_SEED    = 8'hA8;   // 0x55 + 0x53, wrapped
    localparam int          DATA_CELLS  = 8;       // data bytes ahead of the sum byte
    localparam logic [3:0]  LAST_INDEX  = 4'd8;    // index of the sum byte
    localparam logic [15:0] WRAP_LIMIT  = 16'd32728;
    localparam logic [21:0] ANGLE_SCALE = 22'd55;
    localparam logic [21:0] FULL_TURN   = 22'd3600000;
    localparam int          ANGLE_W     = 22;

    typedef logic signed [ANGLE_W-1:0] angle_t;

    // control from the frame sequencer to the datapath, per accepted beat
    typedef struct packed {
        logic shift;      // data byte: push into the cell row
        logic frame_end;  // sum byte: frame complete
        logic sum_ok;     // valid with frame_end
    } ctrl_t;

    // raw*55, minus a full turn at or above the wrap point, in 0.0001 degree
    function automatic angle_t angle_of(input logic [15:0] raw);
        logic [ANGLE_W-1:0] prod;
        begin
            prod = {6'd0, raw} * ANGLE_SCALE;
            if (raw >= WRAP_LIMIT)
            begin
                prod = prod - FULL_TURN;
            end
            angle_of = angle_t'(prod);
        end
    endfunction

endpackage

### hdl/iafp_if.sv
// Handshake interfaces for the received byte channel and the result channel.
// Uses iafp_pkg for the angle type.
interface iafp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface iafp_res_if;
    logic                  valid;
    logic                  ready;
    iafp_pkg::angle_t      roll_angle;
    iafp_pkg::angle_t      pitch_angle;
    iafp_pkg::angle_t      yaw_angle;
    logic [15:0]           version_word;
    logic                  checksum_ok;

    modport source (output valid, output roll_angle, output pitch_angle,
                    output yaw_angle, output version_word, output checksum_ok,
                    input ready);
    modport sink   (input valid, input roll_angle, input pitch_angle,
                    input yaw_angle, input version_word, input checksum_ok,
                    output ready);
endinterface

### hdl/iafp_byte_cell.sv
// One byte cell of the payload row: loads from its neighbor on shift.
// No dependencies.
module iafp_byte_cell
(
    input  logic       clk,
    input  logic       shift,
    input  logic [7:0] d,
    output logic [7:0] q
);

    logic [7:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

### hdl/iafp_frame_ctrl.sv
// Frame sequencer: header hunt, payload count and running sum.
// Depends on iafp_pkg.
module iafp_frame_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              beat,
    input  logic [7:0]        rx_byte,
    output logic              last_next,   // next data beat is the sum byte
    output iafp_pkg::ctrl_t   ctrl
);

    localparam logic [1:0] PH_HUNT1 = 2'd0;
    localparam logic [1:0] PH_HUNT2 = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [3:0] count_reg, count_next;
    logic [7:0] sum_reg, sum_next;
    logic       is_last;

    assign is_last   = (phase_reg == PH_DATA) && (count_reg >= iafp_pkg::LAST_INDEX);
    assign last_next = is_last;

    always_comb
    begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        ctrl.shift     = 1'b0;
        ctrl.frame_end = 1'b0;
        ctrl.sum_ok    = (sum_reg == rx_byte);
        if (beat)
        begin
            unique case (phase_reg)
                PH_HUNT2:
                begin
                    if (rx_byte == iafp_pkg::HDR_SECOND)
                    begin
                        phase_next = PH_DATA;
                        count_next = 4'd0;
                        sum_next   = iafp_pkg::SUM_SEED;
                    end
                    else
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_DATA:
                begin
                    if (is_last)
                    begin
                        ctrl.frame_end = 1'b1;
                        phase_next     = PH_HUNT1;
                        count_next     = 4'd0;
                    end
                    else
                    begin
                        ctrl.shift = 1'b1;
                        count_next = count_reg + 4'd1;
                        sum_next   = sum_reg + rx_byte;
                    end
                end
                default:
                begin
                    if (rx_byte == iafp_pkg::HDR_FIRST)
                    begin
                        phase_next = PH_HUNT2;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT1;
            count_reg <= 4'd0;
            sum_reg   <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

### hdl/imu_angle_frame_parser.sv
// Top level of the IMU angle frame parser.
// Depends on iafp_pkg, iafp_if, iafp_byte_cell and iafp_frame_ctrl.
//
// Takes one received byte per cycle, but for the stall below. After the
// header 0x55 0x53, eight data bytes shift through a row of byte cells
// while a running sum is kept; the ninth byte is compared with that sum. A
// completed frame passes through a frame register and then the result
// register, where the angles are scaled (raw*55, 0.0001 degree) and held: on
// a sum mismatch the result repeats the previous angles with checksum_ok
// low. One result per completed frame. Bytes are taken every cycle; only a
// sum byte can stall, and only while the frame register is full and the
// result register is full and not taken.
module imu_angle_frame_parser
(
    input  logic          clk,
    input  logic          rst_n,
    iafp_rx_if.sink       rx,
    iafp_res_if.source    res
);

    localparam int N = iafp_pkg::DATA_CELLS;

    iafp_pkg::ctrl_t ctrl;
    logic            last_next;
    logic            beat;
    logic [7:0]      cell_q [N];

    logic        frm_vld_reg;
    logic        frm_ok_reg;
    logic [15:0] frm_roll_reg, frm_pitch_reg, frm_yaw_reg, frm_ver_reg;
    logic        frm_move;

    logic             out_vld_reg;
    iafp_pkg::angle_t roll_reg, pitch_reg, yaw_reg;
    logic [15:0]      ver_reg;
    logic             ok_reg;

    assign frm_move = frm_vld_reg && (!out_vld_reg || res.ready);
    assign rx.ready = !(last_next && frm_vld_reg && !frm_move);
    assign beat     = rx.valid && rx.ready;

    iafp_frame_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .beat      (beat),
        .rx_byte   (rx.rx_byte),
        .last_next (last_next),
        .ctrl      (ctrl)
    );

    // new bytes enter at the top cell and walk down to cell 0
    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            iafp_byte_cell u_cell
            (
                .clk   (clk),
                .shift (ctrl.shift),
                .d     ((g == N - 1) ? rx.rx_byte : cell_q[(g + 1) % N]),
                .q     (cell_q[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frm_vld_reg <= 1'b0;
        end
        else if (ctrl.frame_end)
        begin
            frm_vld_reg <= 1'b1;
        end
        else if (frm_move)
        begin
            frm_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.frame_end)
        begin
            frm_ok_reg    <= ctrl.sum_ok;
            frm_roll_reg  <= {cell_q[1], cell_q[0]};
            frm_pitch_reg <= {cell_q[3], cell_q[2]};
            frm_yaw_reg   <= {cell_q[5], cell_q[4]};
            frm_ver_reg   <= {cell_q[7], cell_q[6]};
        end
    end

    // result register; the angle registers are also the held angles
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            roll_reg    <= '0;
            pitch_reg   <= '0;
            yaw_reg     <= '0;
        end
        else if (frm_move)
        begin
            out_vld_reg <= 1'b1;
            if (frm_ok_reg)
            begin
                roll_reg  <= iafp_pkg::angle_of(frm_roll_reg);
                pitch_reg <= iafp_pkg::angle_of(frm_pitch_reg);
                yaw_reg   <= iafp_pkg::angle_of(frm_yaw_reg);
            end
        end
        else if (res.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frm_move)
        begin
            ver_reg <= frm_ver_reg;
            ok_reg  <= frm_ok_reg;
        end
    end

    assign res.valid        = out_vld_reg;
    assign res.roll_angle   = roll_reg;
    assign res.pitch_angle  = pitch_reg;
    assign res.yaw_angle    = yaw_reg;
    assign res.version_word = ver_reg;
    assign res.checksum_ok  = ok_reg;

endmodule

### hdl/iafp_checker.sv
// Port-level checks for the IMU angle frame parser, bound to the top level.
// Depends on iafp_pkg and imu_angle_frame_parser.
module iafp_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             rx_valid,
    input logic             rx_ready,
    input logic             res_valid,
    input logic             res_ready,
    input iafp_pkg::angle_t roll_angle,
    input iafp_pkg::angle_t pitch_angle,
    input iafp_pkg::angle_t yaw_angle,
    input logic             checksum_ok
);

    logic             res_beat;
    iafp_pkg::angle_t last_roll_reg, last_pitch_reg, last_yaw_reg;

    assign res_beat = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_roll_reg  <= '0;
            last_pitch_reg <= '0;
            last_yaw_reg   <= '0;
        end
        else if (res_beat)
        begin
            last_roll_reg  <= roll_angle;
            last_pitch_reg <= pitch_angle;
            last_yaw_reg   <= yaw_angle;
        end
    end

    // a frame with a bad sum repeats the previous angles
    a_bad_sum_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_beat && !checksum_ok |->
            roll_angle == last_roll_reg && pitch_angle == last_pitch_reg
            && yaw_angle == last_yaw_reg)
        else $error("angles changed on a bad-sum frame");

    // input stalls only behind a pending result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !rx_ready |-> res_valid && !res_ready)
        else $error("input stalled with result side free");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(roll_angle)
            && $stable(checksum_ok))
        else $error("result dropped or changed while stalled");

endmodule

bind imu_angle_frame_parser iafp_checker u_iafp_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .rx_valid    (rx.valid),
    .rx_ready    (rx.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .roll_angle  (res.roll_angle),
    .pitch_angle (res.pitch_angle),
    .yaw_angle   (res.yaw_angle),
    .checksum_ok (res.checksum_ok)
);

### verif/tb_imu_angle_frame_parser.sv
`timescale 1ns / 100ps
// Self-checking testbench for imu_angle_frame_parser: random byte stream of
// good, bad-sum and broken frames against a cycle-free frame predictor.
// Depends on iafp_pkg, iafp_if and the parser RTL.
module tb_imu_angle_frame_parser;

    localparam int UNITS_PER_STEP = 55;          // 0.0055 degree per raw step
    localparam int TURN_UNITS     = 3_600_000;   // 360 degrees in 0.0001 degree
    localparam int PAYLOAD_BYTES  = 9;
    localparam int HOLD_CYCLES    = 200;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [1:0]
    {
        HUNT_SYNC    = 2'd0,
        HUNT_ID      = 2'd1,
        TAKE_PAYLOAD = 2'd2
    } parse_phase_e;

    typedef struct
    {
        iafp_pkg::angle_t roll;
        iafp_pkg::angle_t pitch;
        iafp_pkg::angle_t yaw;
        logic [15:0]      version;
        logic             ok;
    } frame_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       byte_valid = 1'b0;
    logic [7:0] byte_data = 8'h00;
    logic       result_ready = 1'b0;
    logic       byte_taken = 1'b0;
    logic       result_taken = 1'b0;

    iafp_rx_if  rx_ch ();
    iafp_res_if res_ch ();

    assign rx_ch.valid   = byte_valid;
    assign rx_ch.rx_byte = byte_data;
    assign res_ch.ready  = result_ready;

    imu_angle_frame_parser i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch)
    );

    logic [7:0]    byte_q[$];
    frame_result_t frame_expect_q[$];

    // predictor state
    parse_phase_e     cur_phase = HUNT_SYNC;
    logic [3:0]       cap_count = 4'd0;
    logic [7:0]       cap_bytes[PAYLOAD_BYTES];
    iafp_pkg::angle_t held_roll = '0;
    iafp_pkg::angle_t held_pitch = '0;
    iafp_pkg::angle_t held_yaw = '0;

    int src_idle_max = 3;
    int sink_idle_max = 3;
    int src_gap = 0;
    int sink_gap = 0;
    bit hold_request = 1'b0;
    bit sink_hold = 1'b0;

    int fault_count = 0;
    int bytes_sent = 0;
    int frames_good = 0;
    int frames_bad = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic iafp_pkg::angle_t scale_raw(input logic [15:0] raw);
        int units;
        units = int'(raw) * UNITS_PER_STEP;
        if (raw >= iafp_pkg::WRAP_LIMIT)
        begin
            units = units - TURN_UNITS;
        end
        return iafp_pkg::angle_t'(units);
    endfunction

    function automatic void track_byte(input logic [7:0] b);
        logic [7:0]    sum;
        frame_result_t res;
        case (cur_phase)
            HUNT_ID:
            begin
                if (b == iafp_pkg::HDR_SECOND)
                begin
                    cur_phase = TAKE_PAYLOAD;
                    cap_count = 4'd0;
                end
                else
                begin
                    cur_phase = HUNT_SYNC;
                end
            end
            TAKE_PAYLOAD:
            begin
                cap_bytes[cap_count] = b;
                cap_count = cap_count + 4'd1;
                if (cap_count == 4'(PAYLOAD_BYTES))
                begin
                    sum = iafp_pkg::HDR_FIRST + iafp_pkg::HDR_SECOND;
                    for (int i = 0; i < PAYLOAD_BYTES - 1; i++)
                    begin
                        sum = sum + cap_bytes[i];
                    end
                    res.ok = (sum == cap_bytes[PAYLOAD_BYTES-1]);
                    if (res.ok)
                    begin
                        held_roll  = scale_raw({cap_bytes[1], cap_bytes[0]});
                        held_pitch = scale_raw({cap_bytes[3], cap_bytes[2]});
                        held_yaw   = scale_raw({cap_bytes[5], cap_bytes[4]});
                    end
                    res.roll    = held_roll;
                    res.pitch   = held_pitch;
                    res.yaw     = held_yaw;
                    res.version = {cap_bytes[7], cap_bytes[6]};
                    frame_expect_q.push_back(res);
                    cur_phase = HUNT_SYNC;
                end
            end
            default:
            begin
                if (b == iafp_pkg::HDR_FIRST)
                begin
                    cur_phase = HUNT_ID;
                end
            end
        endcase
    endfunction

    // corner words come up often so that the wrap point is hit
    function automatic logic [15:0] pick_raw();
        logic [15:0] corners[6] = '{16'd0, 16'd32727, 16'd32728, 16'd32767,
                                    16'd32768, 16'hFFFF};
        if ($urandom_range(0, 3) == 0)
        begin
            return corners[$urandom_range(0, 5)];
        end
        return 16'($urandom);
    endfunction

    task automatic queue_frame(input logic [15:0] r, p, y, ver, input bit good_sum);
        logic [7:0] body[8];
        logic [7:0] sum;
        body = '{r[7:0], r[15:8], p[7:0], p[15:8], y[7:0], y[15:8], ver[7:0], ver[15:8]};
        sum = iafp_pkg::HDR_FIRST + iafp_pkg::HDR_SECOND;
        byte_q.push_back(iafp_pkg::HDR_FIRST);
        byte_q.push_back(iafp_pkg::HDR_SECOND);
        foreach (body[i])
        begin
            sum = sum + body[i];
            byte_q.push_back(body[i]);
        end
        if (!good_sum)
        begin
            sum = sum ^ 8'($urandom_range(1, 255));
        end
        byte_q.push_back(sum);
    endtask

    // mostly well-formed frames; the rest bad sums, broken headers and noise
    task automatic feed_random(input int frame_bytes);
        int queued;
        int choice;
        int n;
        logic [7:0] b;
        queued = 0;
        while (queued < frame_bytes)
        begin
            choice = $urandom_range(0, 9);
            if (choice < 7)
            begin
                queue_frame(pick_raw(), pick_raw(), pick_raw(), pick_raw(), 1'b1);
                queued += 11;
            end
            else if (choice == 7)
            begin
                queue_frame(pick_raw(), pick_raw(), pick_raw(), pick_raw(), 1'b0);
                queued += 11;
            end
            else if (choice == 8)
            begin
                byte_q.push_back(iafp_pkg::HDR_FIRST);
                if ($urandom_range(0, 1) == 0)
                begin
                    byte_q.push_back(iafp_pkg::HDR_FIRST);
                end
                else
                begin
                    do
                    begin
                        b = 8'($urandom);
                    end
                    while (b == iafp_pkg::HDR_SECOND);
                    byte_q.push_back(b);
                end
            end
            else
            begin
                n = $urandom_range(1, 4);
                repeat (n) byte_q.push_back(8'($urandom));
            end
        end
    endtask

    task automatic drain_results();
        while (byte_q.size() != 0 || byte_valid || frame_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // byte source
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
        end
        else if (byte_valid && !byte_taken)
        begin
            // beat still pending, hold it
        end
        else if (src_gap > 0)
        begin
            byte_valid <= 1'b0;
            src_gap <= src_gap - 1;
        end
        else if (byte_q.size() != 0)
        begin
            byte_valid <= 1'b1;
            byte_data <= byte_q.pop_front();
            src_gap <= $urandom_range(0, src_idle_max);
        end
        else
        begin
            byte_valid <= 1'b0;
        end
    end

    // result sink
    always @(negedge clk)
    begin : ready_drive
        int draw;
        if (!rst_n || sink_hold)
        begin
            result_ready <= 1'b0;
        end
        else if (result_taken)
        begin
            draw = $urandom_range(0, sink_idle_max);
            result_ready <= (draw == 0);
            sink_gap <= (draw == 0) ? 0 : draw - 1;
        end
        else if (sink_gap > 0)
        begin
            result_ready <= 1'b0;
            sink_gap <= sink_gap - 1;
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    initial
    begin : sink_hold_off
        wait (hold_request);
        sink_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_hold = 1'b0;
    end

    always @(posedge clk)
    begin
        byte_taken <= rx_ch.valid && rx_ch.ready;
        if (rx_ch.valid && rx_ch.ready)
        begin
            track_byte(rx_ch.rx_byte);
            bytes_sent++;
        end
    end

    always @(posedge clk)
    begin : result_check
        frame_result_t want;
        result_taken <= res_ch.valid && res_ch.ready;
        if (res_ch.valid && res_ch.ready)
        begin
            if (frame_expect_q.size() == 0)
            begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                begin
                    $display("%0t: result beat with no frame pending: roll %0d pitch %0d",
                             $realtime, res_ch.roll_angle, res_ch.pitch_angle);
                end
            end
            else
            begin
                want = frame_expect_q.pop_front();
                if (want.ok)
                begin
                    frames_good++;
                end
                else
                begin
                    frames_bad++;
                end
                if (res_ch.roll_angle !== want.roll || res_ch.pitch_angle !== want.pitch
                    || res_ch.yaw_angle !== want.yaw || res_ch.version_word !== want.version
                    || res_ch.checksum_ok !== want.ok)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                    begin
                        $display("%0t: frame mismatch, exp roll %0d pitch %0d yaw %0d ver %h ok %b",
                                 $realtime, want.roll, want.pitch, want.yaw, want.version,
                                 want.ok);
                        $display("%0t:                 got roll %0d pitch %0d yaw %0d ver %h ok %b",
                                 $realtime, res_ch.roll_angle, res_ch.pitch_angle,
                                 res_ch.yaw_angle, res_ch.version_word, res_ch.checksum_ok);
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wrong second header, then both sides of the wrap point and a bad sum
        byte_q.push_back(iafp_pkg::HDR_FIRST);
        byte_q.push_back(iafp_pkg::HDR_FIRST);
        queue_frame(16'd32727, 16'd32728, 16'hFFFF, 16'hFFFF, 1'b1);
        queue_frame(16'd0, 16'd0, 16'd0, 16'h0000, 1'b0);
        drain_results();

        feed_random(300);
        drain_results();

        src_idle_max = 0;
        sink_idle_max = 0;
        feed_random(150);
        drain_results();

        // back-to-back frames against a stalled sink
        sink_idle_max = 3;
        hold_request = 1'b1;
        repeat (22) queue_frame(pick_raw(), pick_raw(), pick_raw(), pick_raw(), 1'b1);
        drain_results();

        src_idle_max = 3;
        sink_idle_max = 0;
        feed_random(100);
        drain_results();

        repeat (10) @(posedge clk);
        if (frame_expect_q.size() != 0)
        begin
            fault_count++;
        end
        $display("sent %0d bytes; checked %0d frames with good sum, %0d with bad sum",
                 bytes_sent, frames_good, frames_bad);
        $display("covered broken headers, noise, wrap-point words and a %0d-cycle sink stall",
                 HOLD_CYCLES);
        if (fault_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial
    begin : watchdog
        #(5_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
